// ----- rtl/feedback_queue_scheduler_ageing_assert.svh -----
// Assertion macros for the feedback queue scheduler.
// Uses the clock and reset names of the including module.
`ifndef FEEDBACK_QUEUE_SCHEDULER_AGEING_ASSERT_SVH
`define FEEDBACK_QUEUE_SCHEDULER_AGEING_ASSERT_SVH

// cond must hold at every edge out of reset
`define FQSA_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// ante implies cons at the same edge
`define FQSA_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ----- rtl/fqsa_pkg.sv -----
// Shared types, codes and helpers of the feedback queue scheduler.
// No dependencies.
`timescale 1ns / 1ps

package fqsa_pkg;

   localparam int MAX_JOBS_DEF   = 64;
   localparam int MAX_LEVELS_DEF = 5;

   localparam int LVL_W      = 3;
   localparam int CSR_DATA_W = 15;

   localparam logic [15:0] LASTQ_QUANTUM = 16'd10000;
   localparam logic [15:0] QUANTUM_MAX   = 16'hFFFF;

   localparam logic [2:0] EV_ARRIVED    = 3'd0;
   localparam logic [2:0] EV_REJECTED   = 3'd1;
   localparam logic [2:0] EV_DISPATCHED = 3'd2;
   localparam logic [2:0] EV_DEMOTED    = 3'd3;
   localparam logic [2:0] EV_FINISHED   = 3'd4;

   localparam logic CMD_ARRIVAL = 1'b0;

   typedef enum logic [1:0] {
      CSR_NUM_QUEUES,
      CSR_BASE_QUANTUM,
      CSR_QUANTUM_BASE,
      CSR_AGEING_INTERVAL
   } csr_index_type;

   typedef struct packed {
      logic        command;
      logic [15:0] job_id;
      logic [15:0] burst_length;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [15:0] event_job;
      logic [2:0]  level;
      logic [31:0] event_tick;
      logic [31:0] turnaround;
      logic [31:0] waiting;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] job;
      logic [15:0] remaining;
      logic [15:0] initial_burst;
      logic [31:0] arrival;
      logic [15:0] age;
   } slot_word_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RUN_EVAL,
      ST_DISP,
      ST_DISP_SLOT,
      ST_DISP_Q,
      ST_QMUL,
      ST_EMIT,
      ST_AGE_START,
      ST_AGE_POP,
      ST_AGE_SLOT,
      ST_AGE_UPD,
      ST_TICK_END
   } state_type;

   // one step of the quantum power: q * f, clamped to 16 bits
   function automatic logic [15:0] sat_mul(input logic [15:0] q, input logic [2:0] f);
      logic [18:0] p;
      p = 19'(q) * 19'(f);
      if (p > 19'(QUANTUM_MAX)) return QUANTUM_MAX;
      return p[15:0];
   endfunction

endpackage

// ----- rtl/fqsa_ram.sv -----
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module fqsa_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/feedback_queue_scheduler_ageing.sv -----
// Top level of the multilevel feedback queue scheduler with ageing.
// Depends on fqsa_pkg, fqsa_ram and feedback_queue_scheduler_ageing_assert.svh.
`timescale 1ns / 1ps
`include "feedback_queue_scheduler_ageing_assert.svh"

// Non-preemptive multilevel feedback scheduler for one CPU, driven one item
// at a time. An arrival item (command 0) takes the lowest free job slot and
// queues the job at level 0; it gives one result, arrived or rejected when
// all MAX_JOBS slots are taken. A tick item (command 1) charges the running
// job, then lets an idle CPU dispatch from the highest non-empty level, then
// ages the last queue, and gives zero, one or two results (finished or
// demoted, then dispatched); last marks the final result of an item.
// The block takes one item at a time and drops req_ready until it is done.
// An arrival scans the free map from slot 0 up to the first free slot. A
// tick charges the running job if there is one; a dispatch adds a slot
// lookup, then one quantum multiply per level above the chosen round-robin
// level; then the last queue is walked through the shared level FIFO RAM
// and the slot RAM one entry at a time. Each result waits while rsp_ready
// is low.
// The result register frees the input side: the next item is taken while a
// result still waits. Configuration writes (csr_ready is always high) must
// go in only while no item is in flight; the block does not enforce this.
module feedback_queue_scheduler_ageing #(
   parameter int MAX_JOBS   = fqsa_pkg::MAX_JOBS_DEF,
   parameter int MAX_LEVELS = fqsa_pkg::MAX_LEVELS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  fqsa_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output fqsa_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  fqsa_pkg::csr_index_type            csr_index,
   input  logic [fqsa_pkg::CSR_DATA_W-1:0]    csr_data
);

   import fqsa_pkg::*;

   localparam int SLOT_W   = $clog2(MAX_JOBS);
   localparam int CNT_W    = $clog2(MAX_JOBS + 1);
   localparam int LVI_W    = $clog2(MAX_LEVELS);
   localparam int LASTQ    = MAX_LEVELS - 1;
   localparam int FA_DEPTH = MAX_LEVELS * MAX_JOBS;
   localparam int FA_W     = $clog2(FA_DEPTH);
   localparam int SW_W     = $bits(slot_word_type);
   localparam logic [LVL_W-1:0] LASTQ_LV = LVL_W'(LASTQ);

   // ---------------------------------------------------------------- state
   state_type state_ff, state_in, ret_ff, ret_in;

   logic [31:0]         tick_ff, tick_in;
   logic                run_valid_ff, run_valid_in;
   logic [SLOT_W-1:0]   run_slot_ff, run_slot_in;
   logic [15:0]         ql_ff, ql_in;
   logic [LVL_W-1:0]    rlev_ff, rlev_in;
   logic [MAX_JOBS-1:0] free_ff, free_in;
   logic [SLOT_W-1:0]   head_ff [MAX_LEVELS];
   logic [CNT_W-1:0]    cnt_ff  [MAX_LEVELS];

   // configuration
   logic [2:0]  nq_ff;
   logic [7:0]  bq_ff;
   logic [2:0]  qb_ff;
   logic [14:0] ai_ff;

   // working registers of the sequencer
   req_type           req_ff, req_in;
   rsp_type           ev_ff, ev_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0] scan_ff, scan_in;
   logic [SLOT_W-1:0] cur_slot_ff, cur_slot_in;
   logic [CNT_W-1:0]  age_left_ff, age_left_in;
   logic [15:0]       q_ff, q_in;
   logic [2:0]        qcnt_ff, qcnt_in;

   // queue and memory control
   logic              push_en, pop_en, emit_load;
   logic [LVL_W-1:0]  push_lv, pop_lv;
   logic [SLOT_W-1:0] push_slot;
   logic              slot_we;
   logic [SLOT_W-1:0] slot_wr_addr, slot_rd_addr;
   slot_word_type     slot_wr_data, slot_rd;
   logic [SW_W-1:0]   slot_rd_raw;
   logic              fifo_we;
   logic [FA_W-1:0]   fifo_wr_addr, fifo_rd_addr;
   logic [SLOT_W-1:0] fifo_rd;

   // derived
   logic [LVL_W-1:0]  n_eff;
   logic              disp_found, lastq_busy, disp_avail, out_free;
   logic [LVL_W-1:0]  disp_lv;
   logic [CNT_W+2:0]  cnt_sum;

   function automatic logic [FA_W-1:0] fa_addr(input logic [LVL_W-1:0]  lv,
                                               input logic [SLOT_W-1:0] idx);
      return FA_W'(lv) * FA_W'(MAX_JOBS) + FA_W'(idx);
   endfunction

   function automatic logic [SLOT_W-1:0] tail_pos(input logic [SLOT_W-1:0] h,
                                                  input logic [CNT_W-1:0]  c);
      logic [CNT_W:0] s;
      s = (CNT_W+1)'(h) + (CNT_W+1)'(c);
      if (s >= (CNT_W+1)'(MAX_JOBS)) s = s - (CNT_W+1)'(MAX_JOBS);
      return s[SLOT_W-1:0];
   endfunction

   function automatic logic [SLOT_W-1:0] head_next(input logic [SLOT_W-1:0] h);
      return (h == SLOT_W'(MAX_JOBS - 1)) ? '0 : SLOT_W'(h + 1'b1);
   endfunction

   // ------------------------------------------------------------- memories
   // Slot store: one word per job slot.
   fqsa_ram #(
      .WIDTH (SW_W),
      .DEPTH (MAX_JOBS),
      .ADDR_W(SLOT_W)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (slot_we),
      .wr_addr(slot_wr_addr),
      .wr_data(slot_wr_data),
      .rd_addr(slot_rd_addr),
      .rd_data(slot_rd_raw)
   );

   assign slot_rd = slot_word_type'(slot_rd_raw);

   // Level FIFOs: one ring of MAX_JOBS slot indexes per level.
   fqsa_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (FA_DEPTH),
      .ADDR_W(FA_W)
   ) u_fifo_ram (
      .clock  (clock),
      .wr_en  (fifo_we),
      .wr_addr(fifo_wr_addr),
      .wr_data(push_slot),
      .rd_addr(fifo_rd_addr),
      .rd_data(fifo_rd)
   );

   assign fifo_we      = push_en;
   assign fifo_wr_addr = fa_addr(push_lv,
                                 tail_pos(head_ff[push_lv[LVI_W-1:0]],
                                          cnt_ff[push_lv[LVI_W-1:0]]));
   assign fifo_rd_addr = fa_addr(pop_lv, head_ff[pop_lv[LVI_W-1:0]]);

   // ------------------------------------------------------------- derived
   always_comb begin
      n_eff = nq_ff;
      if (nq_ff < 3'd3) n_eff = 3'd3;
      if (nq_ff > LVL_W'(MAX_LEVELS)) n_eff = LVL_W'(MAX_LEVELS);
   end

   // highest non-empty round-robin level; lowest index wins
   always_comb begin
      disp_found = 1'b0;
      disp_lv    = '0;
      for (int i = MAX_LEVELS - 2; i >= 0; i--) begin
         if (((LVL_W+1)'(i + 1) < {1'b0, n_eff}) && (cnt_ff[i] != '0)) begin
            disp_found = 1'b1;
            disp_lv    = LVL_W'(i);
         end
      end
   end

   always_comb begin
      cnt_sum = '0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
         cnt_sum = cnt_sum + (CNT_W+3)'(cnt_ff[i]);
      end
   end

   assign lastq_busy = (cnt_ff[LASTQ] != '0);
   assign disp_avail = disp_found || lastq_busy;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // ---------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.command == CMD_ARRIVAL) state_in = ST_SCAN;
               else if (run_valid_ff)              state_in = ST_RUN_EVAL;
               else                                state_in = ST_DISP;
            end
         end
         ST_SCAN: begin
            if (free_ff[scan_ff] || (scan_ff == SLOT_W'(MAX_JOBS - 1))) state_in = ST_EMIT;
         end
         ST_RUN_EVAL: begin
            if ((ql_ff > 16'd1) && (slot_rd.remaining > 16'd1)) state_in = ST_DISP;
            else                                                 state_in = ST_EMIT;
         end
         ST_DISP: begin
            if (!run_valid_ff && disp_avail) state_in = ST_DISP_SLOT;
            else                             state_in = ST_AGE_START;
         end
         ST_DISP_SLOT: state_in = ST_DISP_Q;
         ST_DISP_Q:    state_in = ST_QMUL;
         ST_QMUL: begin
            if (qcnt_ff == 3'd0) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) state_in = ret_ff;
         end
         ST_AGE_START: begin
            if (lastq_busy) state_in = ST_AGE_POP;
            else            state_in = ST_TICK_END;
         end
         ST_AGE_POP:  state_in = ST_AGE_SLOT;
         ST_AGE_SLOT: state_in = ST_AGE_UPD;
         ST_AGE_UPD: begin
            if (age_left_ff == '0) state_in = ST_TICK_END;
            else                   state_in = ST_AGE_POP;
         end
         ST_TICK_END: state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------ outputs and datapath
   always_comb begin
      logic [15:0] burst;
      logic [31:0] ta;

      ret_in       = ret_ff;
      tick_in      = tick_ff;
      run_valid_in = run_valid_ff;
      run_slot_in  = run_slot_ff;
      ql_in        = ql_ff;
      rlev_in      = rlev_ff;
      free_in      = free_ff;
      req_in       = req_ff;
      ev_in        = ev_ff;
      scan_in      = scan_ff;
      cur_slot_in  = cur_slot_ff;
      age_left_in  = age_left_ff;
      q_in         = q_ff;
      qcnt_in      = qcnt_ff;

      req_ready    = 1'b0;
      push_en      = 1'b0;
      push_lv      = '0;
      push_slot    = run_slot_ff;
      pop_en       = 1'b0;
      pop_lv       = '0;
      slot_we      = 1'b0;
      slot_wr_addr = run_slot_ff;
      slot_wr_data = slot_rd;
      slot_rd_addr = run_slot_ff;
      emit_load    = 1'b0;

      burst = (req_ff.burst_length == 16'd0) ? 16'd1 : req_ff.burst_length;
      ta    = tick_ff - slot_rd.arrival;

      ev_in.event_tick = tick_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in  = req_data;
               scan_in = '0;
            end
         end

         // lowest free slot, one per cycle
         ST_SCAN: begin
            ev_in.event_job  = req_ff.job_id;
            ev_in.level      = '0;
            ev_in.turnaround = '0;
            ev_in.waiting    = '0;
            ev_in.last       = 1'b1;
            ret_in           = ST_IDLE;
            if (free_ff[scan_ff]) begin
               slot_we                    = 1'b1;
               slot_wr_addr               = scan_ff;
               slot_wr_data.job           = req_ff.job_id;
               slot_wr_data.remaining     = burst;
               slot_wr_data.initial_burst = burst;
               slot_wr_data.arrival       = tick_ff;
               slot_wr_data.age           = '0;
               free_in[scan_ff]           = 1'b0;
               push_en                    = 1'b1;
               push_lv                    = '0;
               push_slot                  = scan_ff;
               ev_in.event_res            = EV_ARRIVED;
            end else if (scan_ff == SLOT_W'(MAX_JOBS - 1)) begin
               ev_in.event_res = EV_REJECTED;
            end else begin
               scan_in = SLOT_W'(scan_ff + 1'b1);
            end
         end

         // charge the running job one tick
         ST_RUN_EVAL: begin
            ev_in.event_job = slot_rd.job;
            ret_in          = ST_DISP;
            if ((ql_ff > 16'd1) && (slot_rd.remaining > 16'd1)) begin
               ql_in                  = ql_ff - 16'd1;
               slot_we                = 1'b1;
               slot_wr_data.remaining = slot_rd.remaining - 16'd1;
            end else if (slot_rd.remaining <= 16'd1) begin
               free_in[run_slot_ff] = 1'b1;
               run_valid_in         = 1'b0;
               ev_in.event_res      = EV_FINISHED;
               ev_in.level          = '0;
               ev_in.turnaround     = ta;
               ev_in.waiting        = ta - 32'(slot_rd.initial_burst);
               ev_in.last           = !disp_avail;
            end else begin
               slot_we                = 1'b1;
               slot_wr_data.remaining = slot_rd.remaining - 16'd1;
               push_en                = 1'b1;
               if (({1'b0, rlev_ff} + 4'd2) < {1'b0, n_eff}) begin
                  push_lv     = LVL_W'(rlev_ff + 1'b1);
                  ev_in.level = LVL_W'(rlev_ff + 1'b1);
               end else begin
                  push_lv          = LASTQ_LV;
                  ev_in.level      = LVL_W'(n_eff - 1'b1);
                  slot_wr_data.age = 16'(ai_ff) + 16'd1;
               end
               run_valid_in     = 1'b0;
               ql_in            = '0;
               ev_in.event_res  = EV_DEMOTED;
               ev_in.turnaround = '0;
               ev_in.waiting    = '0;
               ev_in.last       = 1'b0;
            end
         end

         ST_DISP: begin
            if (!run_valid_ff && disp_avail) begin
               pop_en = 1'b1;
               if (disp_found) begin
                  pop_lv  = disp_lv;
                  rlev_in = disp_lv;
                  q_in    = 16'(bq_ff);
                  qcnt_in = disp_lv;
               end else begin
                  pop_lv  = LASTQ_LV;
                  rlev_in = LVL_W'(n_eff - 1'b1);
                  q_in    = LASTQ_QUANTUM;
                  qcnt_in = '0;
               end
            end
         end

         ST_DISP_SLOT: begin
            slot_rd_addr = fifo_rd;
            run_slot_in  = fifo_rd;
            run_valid_in = 1'b1;
         end

         ST_DISP_Q: begin
            slot_rd_addr     = run_slot_ff;
            ev_in.event_res  = EV_DISPATCHED;
            ev_in.event_job  = slot_rd.job;
            ev_in.level      = rlev_ff;
            ev_in.turnaround = '0;
            ev_in.waiting    = '0;
            ev_in.last       = 1'b1;
            ret_in           = ST_AGE_START;
         end

         // round-robin levels: quantum = base_quantum * quantum_base^level, one factor a cycle
         ST_QMUL: begin
            if (qcnt_ff == 3'd0) begin
               ql_in = q_ff;
            end else begin
               q_in    = sat_mul(q_ff, qb_ff);
               qcnt_in = qcnt_ff - 3'd1;
            end
         end

         ST_EMIT: begin
            emit_load = out_free;
         end

         ST_AGE_START: begin
            age_left_in = cnt_ff[LASTQ];
         end

         ST_AGE_POP: begin
            pop_en      = 1'b1;
            pop_lv      = LASTQ_LV;
            age_left_in = age_left_ff - 1'b1;
         end

         ST_AGE_SLOT: begin
            slot_rd_addr = fifo_rd;
            cur_slot_in  = fifo_rd;
         end

         ST_AGE_UPD: begin
            push_en   = 1'b1;
            push_slot = cur_slot_ff;
            if (slot_rd.age > 16'd1) begin
               slot_we          = 1'b1;
               slot_wr_addr     = cur_slot_ff;
               slot_wr_data.age = slot_rd.age - 16'd1;
               push_lv          = LASTQ_LV;
            end else begin
               push_lv = LVL_W'(n_eff - 3'd2);
            end
         end

         ST_TICK_END: begin
            tick_in = tick_ff + 32'd1;
         end

         default: begin
            ret_in = ST_IDLE;
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_data_in = emit_load ? ev_ff : rsp_data_ff;
      if (emit_load)      rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else                rsp_valid_in = rsp_valid_ff;
   end

   // ------------------------------------------------------------ registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         tick_ff      <= '0;
         run_valid_ff <= 1'b0;
         ql_ff        <= '0;
         rlev_ff      <= '0;
         free_ff      <= '1;
         rsp_valid_ff <= 1'b0;
         nq_ff        <= 3'd3;
         bq_ff        <= 8'd1;
         qb_ff        <= 3'd2;
         ai_ff        <= 15'd100;
         for (int i = 0; i < MAX_LEVELS; i++) begin
            head_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         tick_ff      <= tick_in;
         run_valid_ff <= run_valid_in;
         ql_ff        <= ql_in;
         rlev_ff      <= rlev_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < MAX_LEVELS; i++) begin
            if (pop_en && (pop_lv == LVL_W'(i))) begin
               head_ff[i] <= head_next(head_ff[i]);
               cnt_ff[i]  <= cnt_ff[i] - 1'b1;
            end else if (push_en && (push_lv == LVL_W'(i))) begin
               cnt_ff[i]  <= cnt_ff[i] + 1'b1;
            end
         end
         if (csr_valid) begin
            unique case (csr_index)
               CSR_NUM_QUEUES:      nq_ff <= csr_data[2:0];
               CSR_BASE_QUANTUM:    bq_ff <= csr_data[7:0];
               CSR_QUANTUM_BASE:    qb_ff <= csr_data[2:0];
               CSR_AGEING_INTERVAL: ai_ff <= csr_data[14:0];
               default:             nq_ff <= nq_ff;
            endcase
         end
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      run_slot_ff <= run_slot_in;
      req_ff      <= req_in;
      ev_ff       <= ev_in;
      rsp_data_ff <= rsp_data_in;
      scan_ff     <= scan_in;
      cur_slot_ff <= cur_slot_in;
      age_left_ff <= age_left_in;
      q_ff        <= q_in;
      qcnt_ff     <= qcnt_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   // ----------------------------------------------------------- assertions
   logic books_ok, tick_ok;

   assign books_ok = ($countones(~free_ff) == int'(cnt_sum) + int'(run_valid_ff));
   assign tick_ok  = (tick_in == tick_ff) || (tick_in == tick_ff + 32'd1);

   // the running job always owns an occupied slot
   `FQSA_ASSERT_IMPLY(a_run_slot_held, run_valid_ff, !free_ff[run_slot_ff], "running slot is free")
   // between items every occupied slot is queued once or running
   `FQSA_ASSERT_IMPLY(a_slot_books, state_ff == ST_IDLE, books_ok, "slot and queue counts differ")
   // the tick counter only ever steps by one
   `FQSA_ASSERT_ALWAYS(a_tick_step, tick_ok, "tick counter jumped")

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench of the feedback queue scheduler with ageing.
// Depends on fqsa_pkg and feedback_queue_scheduler_ageing; predicts every result itself.
`timescale 1ns / 1ps

module tb;
   import fqsa_pkg::*;

   localparam int JOBS       = 64;
   localparam int LEVELS     = 5;
   localparam int LASTQ      = LEVELS - 1;
   localparam int IDLE_SLOT  = JOBS;
   localparam int SETTLE     = 400;    // cycles after the last result: a full last-queue walk
   localparam int STALL_MAX  = 20000;  // cycles with no handshake before giving up
   localparam int RUN_ITEMS  = 1450;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   csr_index_type csr_index = CSR_NUM_QUEUES;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   feedback_queue_scheduler_ageing dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Scheduler shadow: slots, level FIFOs, CPU and tick counter
   // ---------------------------------------------------------------
   logic [15:0] job_pid   [JOBS];
   logic [15:0] job_left  [JOBS];
   logic [15:0] job_burst [JOBS];
   logic [31:0] job_born  [JOBS];
   logic [15:0] job_age   [JOBS];
   bit          slot_free [JOBS];
   int          level_q   [LEVELS][$];
   logic [31:0] sched_tick;
   int          cpu_slot;
   logic [31:0] cpu_quantum;
   logic [31:0] cpu_level;

   logic [2:0]  reg_levels;
   logic [7:0]  reg_quantum;
   logic [2:0]  reg_factor;
   logic [14:0] reg_ageing;

   rsp_type events_due[$];     // predicted results not yet seen
   int      errors = 0;
   int      items_sent = 0, events_seen = 0, rejects_seen = 0, finishes_seen = 0;
   bit      calm = 1'b0;       // no idling on either side
   int      quiet_cycles = 0;
   logic [15:0] pid_floor = 16'd0;  // last pid queued in this tick

   function automatic int occupied_slots();
      int c = 0;
      for (int i = 0; i < JOBS; i++) if (!slot_free[i]) c++;
      return c;
   endfunction

   function automatic void sched_clear();
      for (int i = 0; i < JOBS; i++) slot_free[i] = 1'b1;
      for (int l = 0; l < LEVELS; l++) level_q[l].delete();
      sched_tick  = '0;
      cpu_slot    = IDLE_SLOT;
      cpu_quantum = '0;
      cpu_level   = '0;
      reg_levels  = 3'd3;
      reg_quantum = 8'd1;
      reg_factor  = 3'd2;
      reg_ageing  = 15'd100;
   endfunction

   function automatic void enqueue_level(int lv, int s);
      if (level_q[lv].size() < JOBS) level_q[lv] = {level_q[lv], s};
   endfunction

   function automatic logic [31:0] quantum_of(int lv);
      logic [31:0] q = 32'(reg_quantum);
      for (int i = 0; i < lv; i++) begin
         q = q * 32'(reg_factor);
         if (q > 32'd65535) q = 32'd65535;
      end
      return q;
   endfunction

   function automatic void note_event(logic [2:0] ev, logic [15:0] pid, logic [31:0] lv,
                                      logic [31:0] ta, logic [31:0] wt);
      rsp_type r;
      r.event_res  = ev;
      r.event_job  = pid;
      r.level      = lv[2:0];
      r.event_tick = sched_tick;
      r.turnaround = ta;
      r.waiting    = wt;
      r.last       = 1'b0;
      events_due = {events_due, r};
   endfunction

   // works out the results of one accepted item and advances the shadow
   function automatic void schedule_item(req_type it);
      int k = 0;
      int s, dest, lv, n, cnt;
      logic [15:0] burst;
      logic [31:0] ta;
      if (it.command == CMD_ARRIVAL) begin
         burst = (it.burst_length == 16'd0) ? 16'd1 : it.burst_length;
         s = JOBS;
         for (int i = JOBS - 1; i >= 0; i--) if (slot_free[i]) s = i;
         if (s == JOBS) begin
            note_event(EV_REJECTED, it.job_id, 0, 0, 0);
         end else begin
            slot_free[s] = 1'b0;
            job_pid[s]   = it.job_id;
            job_left[s]  = burst;
            job_burst[s] = burst;
            job_born[s]  = sched_tick;
            job_age[s]   = '0;
            enqueue_level(0, s);
            note_event(EV_ARRIVED, it.job_id, 0, 0, 0);
         end
         events_due[$].last = 1'b1;
         return;
      end
      n = (reg_levels < 3) ? 3 : (reg_levels > LEVELS ? LEVELS : int'(reg_levels));
      // charge the running job
      if (cpu_slot != IDLE_SLOT) begin
         s = cpu_slot;
         if (cpu_quantum > 1 && job_left[s] > 1) begin
            cpu_quantum--;
            job_left[s]--;
         end else if (job_left[s] <= 1) begin
            ta = sched_tick - job_born[s];
            slot_free[s] = 1'b1;
            cpu_slot = IDLE_SLOT;
            note_event(EV_FINISHED, job_pid[s], 0, ta, ta - 32'(job_burst[s]));
            k++;
         end else begin
            job_left[s]--;
            if (cpu_level + 2 < n) begin
               dest = cpu_level + 1;
               enqueue_level(dest, s);
            end else begin
               dest = n - 1;
               job_age[s] = 16'(reg_ageing) + 16'd1;
               enqueue_level(LASTQ, s);
            end
            cpu_slot = IDLE_SLOT;
            cpu_quantum = '0;
            note_event(EV_DEMOTED, job_pid[s], dest, 0, 0);
            k++;
         end
      end
      // idle CPU picks from the highest non-empty level
      if (cpu_slot == IDLE_SLOT) begin
         lv = LEVELS;
         for (int i = 0; i + 1 < n; i++)
            if (lv == LEVELS && level_q[i].size() > 0) lv = i;
         if (lv != LEVELS) begin
            cpu_slot = level_q[lv].pop_front();
            cpu_level = lv;
            cpu_quantum = quantum_of(lv);
         end else if (level_q[LASTQ].size() > 0) begin
            cpu_slot = level_q[LASTQ].pop_front();
            cpu_level = n - 1;
            cpu_quantum = 32'(LASTQ_QUANTUM);
         end
         if (cpu_slot != IDLE_SLOT) begin
            note_event(EV_DISPATCHED, job_pid[cpu_slot], cpu_level, 0, 0);
            k++;
         end
      end
      // ageing of the last queue, in queue order
      cnt = level_q[LASTQ].size();
      for (int i = 0; i < cnt; i++) begin
         s = level_q[LASTQ].pop_front();
         if (job_age[s] > 1) begin
            job_age[s]--;
            enqueue_level(LASTQ, s);
         end else begin
            enqueue_level(n - 2, s);
         end
      end
      sched_tick = sched_tick + 1;
      if (k > 0) events_due[$].last = 1'b1;
   endfunction

   // ---------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------
   task automatic send_item(req_type it);
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      schedule_item(it);
      items_sent++;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   task automatic send_tick();
      req_type it;
      it.command      = ~CMD_ARRIVAL;
      it.job_id       = 16'($urandom);
      it.burst_length = 16'($urandom);
      pid_floor = '0;
      send_item(it);
   endtask

   // arrivals within one tick must carry rising pids
   task automatic send_arrival(logic [15:0] pid, logic [15:0] burst);
      req_type it;
      if (pid <= pid_floor) send_tick();
      it.command      = CMD_ARRIVAL;
      it.job_id       = pid;
      it.burst_length = burst;
      pid_floor = pid;
      send_item(it);
   endtask

   // csr_valid stays high across back-to-back writes; set_config drops it
   task automatic write_reg(csr_index_type idx, int unsigned value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_NUM_QUEUES:      reg_levels  = 3'(value);
         CSR_BASE_QUANTUM:    reg_quantum = 8'(value);
         CSR_QUANTUM_BASE:    reg_factor  = 3'(value);
         CSR_AGEING_INTERVAL: reg_ageing  = 15'(value);
      endcase
   endtask

   // sender holds off until every result is in and the block has settled
   task automatic wait_settled();
      req_valid <= 1'b0;
      while (events_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_config(int unsigned nq, int unsigned bq, int unsigned qb, int unsigned ai);
      wait_settled();
      write_reg(CSR_NUM_QUEUES, nq);
      write_reg(CSR_BASE_QUANTUM, bq);
      write_reg(CSR_QUANTUM_BASE, qb);
      write_reg(CSR_AGEING_INTERVAL, ai);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] pick_burst();
      int r = $urandom_range(0, 99);
      if (r < 80) return 16'($urandom_range(1, 12));
      if (r < 97) return 16'($urandom_range(13, 300));
      return 16'($urandom_range(1, 65535));
   endfunction

   // mostly ticks, with arrivals in ascending pid runs; more ticks when slots run low
   task automatic random_traffic(int count);
      logic [15:0] pid;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < (occupied_slots() > 48 ? 80 : 55)) begin
            send_tick();
         end else begin
            if (pid_floor == 0) pid = 16'($urandom_range(1, 65000));
            else if (pid_floor > 16'd65000) pid = 16'd65535;
            else pid = pid_floor + 16'($urandom_range(1, 300));
            send_arrival(pid, pick_burst());
         end
      end
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   task automatic test_extremes();
      send_arrival(16'd1, 16'd1);
      send_arrival(16'd65535, 16'd2);
      send_tick();
      send_tick();                                // pid 1 finishes
      send_arrival(16'd7, 16'hFFFF);              // huge burst, ages in the last queue
      repeat (8) send_tick();
   endtask

   task automatic test_fill_slots();
      // a full table rejects; then drain it
      for (int i = 0; i < JOBS + 2; i++) send_arrival(16'(100 + i), 16'd1);
      repeat (80) send_tick();
   endtask

   task automatic test_zero_quantum();
      set_config(0, 0, 0, 0);                     // levels saturate to 3, quantum 0
      send_arrival(16'd20, 16'd5);
      send_arrival(16'd21, 16'd3);
      repeat (14) send_tick();
   endtask

   task automatic test_phase(int unsigned nq, int unsigned bq, int unsigned qb, int unsigned ai,
                             int count);
      set_config(nq, bq, qb, ai);
      random_traffic(count);
   endtask

   task automatic test_level_cut();
      // jobs left on deep levels stall until the count is raised again
      set_config(5, 1, 1, 3);
      for (int i = 0; i < 6; i++) send_arrival(16'(300 + i), 16'd9);
      repeat (30) send_tick();
      set_config(3, 1, 1, 3);
      random_traffic(60);
      set_config(7, 2, 2, 4);
      random_traffic(60);
   endtask

   initial begin
      sched_clear();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_fill_slots();
      test_zero_quantum();
      test_phase(3, 1, 1, 0, 180);
      test_phase(5, 255, 4, 32767, 180);
      test_level_cut();
      test_phase(4, 3, 3, 7, 200);
      test_phase(5, 2, 2, 1, 200);
      test_phase(3, 1, 2, 100, 150);
      calm = 1'b1;
      random_traffic(RUN_ITEMS - items_sent > 0 ? RUN_ITEMS - items_sent : 50);
      wait_settled();
      $display("%0d items sent, %0d results checked (%0d finished, %0d rejected)",
               items_sent, events_seen, finishes_seen, rejects_seen);
      $display("covered fill and reject, quantum and ageing extremes, level count changes");
      if (errors == 0)
         $display("feedback_queue_scheduler_ageing: match");
      else
         $display("feedback_queue_scheduler_ageing: mismatch");
      $finish;
   end

   // ---------------------------------------------------------------
   // Result side: random back-pressure and checking
   // ---------------------------------------------------------------
   int stall_left = 0;
   always @(posedge clock) begin
      if (!calm && stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!calm && $urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 9);
      end
   end

   task automatic field_check(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         events_seen++;
         if (rsp_data.event_res == EV_REJECTED) rejects_seen++;
         if (rsp_data.event_res == EV_FINISHED) finishes_seen++;
         if (events_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, got %h", $time, rsp_data);
         end else begin
            want = events_due.pop_front();
            field_check("event_res", want.event_res, rsp_data.event_res);
            field_check("event_job", want.event_job, rsp_data.event_job);
            field_check("level", want.level, rsp_data.level);
            field_check("event_tick", want.event_tick, rsp_data.event_tick);
            field_check("turnaround", want.turnaround, rsp_data.turnaround);
            field_check("waiting", want.waiting, rsp_data.waiting);
            field_check("last", want.last, rsp_data.last);
         end
      end
   end

   // watchdog: too long without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_valid)
         quiet_cycles <= 0;
      else if (quiet_cycles >= STALL_MAX) begin
         $display("%0t: no progress, %0d results outstanding", $time, events_due.size());
         $display("feedback_queue_scheduler_ageing: mismatch");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/fqsa_pkg.sv
rtl/fqsa_ram.sv
rtl/feedback_queue_scheduler_ageing.sv
tb/tb.sv
